// ----- rtl/crfl_pkg.sv -----
// shared types and constants of the range free-list allocator
package crfl_pkg;

    localparam int MAX_SLOTS  = 256;
    localparam int MAX_RANGES = 128;

    localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int ADDR_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W  = $clog2(MAX_RANGES + 1);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_SCAN,
        ST_MERGE_RD,
        ST_MERGE_CHK,
        ST_MOVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0] hi;
        logic [SLOT_W-1:0] lo;
    } t_range;

endpackage

// ----- rtl/coalescing_range_free_list_allocator.sv -----
// range free-list slot allocator: one range table walked by a sequencer
//
// Free slots live as sorted half-open ranges in a 128-entry table with one write and one
// registered read per cycle; every operation goes through that table, so the cost of an
// item follows from how many ranges it must read or move. After reset the block loads the
// full range in ST_INIT before s_axis_tready rises. Clear and ignored requests go straight
// to ST_DONE; an allocate reads the first range and trims it, or shifts the table down when
// the first range runs empty. A free scans the table up to the range position of its
// index, and when a range is inserted or two ranges are joined the rest of the table moves
// by one entry. A finished result sits in the output register, so the next transfer is
// taken while the result still waits.
module coalescing_range_free_list_allocator
    import crfl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SLOT_W-1:0] i_cfg_wdata,    // pool_capacity
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IDX_W-1:0]  s_axis_tdata,   // slot_index
    input  logic [1:0]        s_axis_tuser,   // operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [IDX_W-1:0]  m_axis_tdata,   // granted_index
    output logic              m_axis_tuser    // status
);

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_cap;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [SLOT_W-1:0] r_s, n_s;
    logic              r_up, n_up;
    logic [IDX_W-1:0]  r_h, n_h;
    logic [IDX_W-1:0]  r_gnt, n_gnt;
    logic              r_st, n_st;
    logic              r_rv;
    logic [ADDR_W-1:0] r_ra;
    t_range            r_rd;
    t_range            r_mem [MAX_RANGES];

    logic              r_ovalid;
    logic [IDX_W-1:0]  r_odata;
    logic              r_ouser;

    logic              w_we, w_re;
    logic [ADDR_W-1:0] w_wa, w_ra;
    t_range            w_wd;

    logic              w_xfer;
    t_op               w_op;
    logic [SLOT_W-1:0] w_eff;
    logic [SLOT_W-1:0] w_h, w_h1, w_in_h;
    logic              w_full;
    logic              w_hit_end, w_hit_start, w_hit_ins, w_last, w_scan_term;
    logic [SLOT_W-1:0] w_alloc_next;
    logic              w_alloc_keep;
    logic              w_has_next, w_join, w_mv_done, w_out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_xfer        = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_in_h        = {1'b0, s_axis_tdata};

    assign w_eff = (r_cap == '0) ? SLOT_W'(1) :
                   (r_cap > SLOT_W'(MAX_SLOTS)) ? SLOT_W'(MAX_SLOTS) : r_cap;

    assign w_h    = {1'b0, r_h};
    assign w_h1   = w_h + SLOT_W'(1);
    assign w_full = (r_cnt == CNT_W'(MAX_RANGES));

    assign w_hit_end   = r_rv && (r_rd.hi == w_h);
    assign w_hit_start = r_rv && !w_hit_end && (r_rd.lo == w_h1);
    assign w_hit_ins   = r_rv && !w_hit_end && !w_hit_start && (r_rd.lo > w_h);
    assign w_last      = r_rv && !w_hit_end && !w_hit_start && !w_hit_ins
                         && ({1'b0, r_ra} == (r_cnt - CNT_W'(1)));
    assign w_scan_term = w_hit_end || w_hit_start || w_hit_ins || w_last;

    assign w_alloc_next = r_rd.lo + SLOT_W'(1);
    assign w_alloc_keep = (w_alloc_next < r_rd.hi);

    assign w_has_next = (({1'b0, r_pos} + CNT_W'(1)) < r_cnt);
    assign w_join     = (r_rd.lo == w_h1);
    assign w_mv_done  = (r_left == '0) && !r_rv;
    assign w_out_free = !r_ovalid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_xfer) begin
                    case (w_op)
                        OP_ALLOC: n_state = (r_cnt == '0) ? ST_DONE : ST_ALLOC_RD;
                        OP_FREE: begin
                            if (w_in_h >= w_eff || r_cnt == '0) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_ALLOC_RD:  n_state = ST_ALLOC_CHK;
            ST_ALLOC_CHK: n_state = w_alloc_keep ? ST_DONE : ST_MOVE;
            ST_SCAN: begin
                if (w_hit_end) begin
                    n_state = ST_MERGE_RD;
                end else if (w_hit_ins && !w_full) begin
                    n_state = ST_MOVE;
                end else if (w_scan_term) begin
                    n_state = ST_DONE;
                end
            end
            ST_MERGE_RD:  n_state = w_has_next ? ST_MERGE_CHK : ST_DONE;
            ST_MERGE_CHK: n_state = w_join ? ST_MOVE : ST_DONE;
            ST_MOVE:      n_state = w_mv_done ? ST_DONE : ST_MOVE;
            ST_DONE:      n_state = w_out_free ? ST_IDLE : ST_DONE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // table access and working registers
    always_comb begin
        w_we   = 1'b0;
        w_wa   = '0;
        w_wd   = '0;
        w_re   = 1'b0;
        w_ra   = '0;
        n_cnt  = r_cnt;
        n_rp   = r_rp;
        n_left = r_left;
        n_pos  = r_pos;
        n_s    = r_s;
        n_up   = r_up;
        n_h    = r_h;
        n_gnt  = r_gnt;
        n_st   = r_st;
        case (r_state)
            ST_INIT: begin
                w_we  = 1'b1;
                w_wd  = '{hi: w_eff, lo: '0};
                n_cnt = CNT_W'(1);
            end
            ST_IDLE: begin
                if (w_xfer) begin
                    n_h   = s_axis_tdata;
                    n_gnt = '0;
                    n_st  = (w_op == OP_ALLOC) && (r_cnt == '0);
                    case (w_op)
                        OP_CLEAR: begin
                            w_we  = 1'b1;
                            w_wd  = '{hi: w_eff, lo: '0};
                            n_cnt = CNT_W'(1);
                        end
                        OP_FREE: begin
                            if (w_in_h < w_eff && r_cnt == '0) begin
                                w_we  = 1'b1;
                                w_wd  = '{hi: w_in_h + SLOT_W'(1), lo: w_in_h};
                                n_cnt = CNT_W'(1);
                            end
                            n_rp   = '0;
                            n_left = r_cnt;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ALLOC_RD: begin
                w_re = 1'b1;
            end
            ST_ALLOC_CHK: begin
                n_gnt = r_rd.lo[IDX_W-1:0];
                if (w_alloc_keep) begin
                    w_we = 1'b1;
                    w_wd = '{hi: r_rd.hi, lo: w_alloc_next};
                end else begin
                    n_rp   = ADDR_W'(1);
                    n_left = r_cnt - CNT_W'(1);
                    n_up   = 1'b0;
                end
            end
            ST_SCAN: begin
                if (w_hit_end) begin
                    n_s   = r_rd.lo;
                    n_pos = r_ra;
                end else if (w_hit_start) begin
                    w_we = 1'b1;
                    w_wa = r_ra;
                    w_wd = '{hi: r_rd.hi, lo: w_h};
                end else if (w_hit_ins) begin
                    n_rp   = ADDR_W'(r_cnt - CNT_W'(1));
                    n_left = r_cnt - {1'b0, r_ra};
                    n_pos  = r_ra;
                    n_up   = 1'b1;
                end else if (w_last) begin
                    if (!w_full) begin
                        w_we  = 1'b1;
                        w_wa  = r_cnt[ADDR_W-1:0];
                        w_wd  = '{hi: w_h1, lo: w_h};
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                if (!w_scan_term && r_left != '0) begin
                    w_re   = 1'b1;
                    w_ra   = r_rp;
                    n_rp   = r_rp + ADDR_W'(1);
                    n_left = r_left - CNT_W'(1);
                end
            end
            ST_MERGE_RD: begin
                if (w_has_next) begin
                    w_re = 1'b1;
                    w_ra = r_pos + ADDR_W'(1);
                end else begin
                    w_we = 1'b1;
                    w_wa = r_pos;
                    w_wd = '{hi: w_h1, lo: r_s};
                end
            end
            ST_MERGE_CHK: begin
                w_we = 1'b1;
                w_wa = r_pos;
                if (w_join) begin
                    w_wd   = '{hi: r_rd.hi, lo: r_s};
                    n_rp   = r_pos + ADDR_W'(2);
                    n_left = r_cnt - {1'b0, r_pos} - CNT_W'(2);
                    n_up   = 1'b0;
                end else begin
                    w_wd = '{hi: w_h1, lo: r_s};
                end
            end
            ST_MOVE: begin
                if (r_rv) begin
                    w_we = 1'b1;
                    w_wa = r_up ? (r_ra + ADDR_W'(1)) : (r_ra - ADDR_W'(1));
                    w_wd = r_rd;
                end
                if (r_left != '0) begin
                    w_re   = 1'b1;
                    w_ra   = r_rp;
                    n_rp   = r_up ? (r_rp - ADDR_W'(1)) : (r_rp + ADDR_W'(1));
                    n_left = r_left - CNT_W'(1);
                end
                if (w_mv_done) begin
                    if (r_up) begin
                        w_we  = 1'b1;
                        w_wa  = r_pos;
                        w_wd  = '{hi: w_h1, lo: w_h};
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // range table
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= r_mem[w_ra];
            r_ra <= w_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_cap    <= SLOT_W'(MAX_SLOTS);
            r_cnt    <= CNT_W'(1);
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rv    <= w_re;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rp   <= n_rp;
        r_left <= n_left;
        r_pos  <= n_pos;
        r_s    <= n_s;
        r_up   <= n_up;
        r_h    <= n_h;
        r_gnt  <= n_gnt;
        r_st   <= n_st;
        if (r_state == ST_DONE && w_out_free) begin
            r_odata <= r_gnt;
            r_ouser <= r_st;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

// ----- rtl/crfl_chk.sv -----
// port-level checker for the range free-list allocator and its bind
module crfl_chk
    import crfl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [IDX_W-1:0]  m_axis_tdata,
    input logic              m_axis_tuser
);

    // input ready is low in the cycle after a transfer in
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // a failed allocate never carries a granted slot
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("exhausted status with nonzero slot");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("handshake active right after reset");

endmodule

bind coalescing_range_free_list_allocator crfl_chk u_crfl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
